// ===== rtl/tcsc_pkg.sv =====
// Package for the translation cache: shared types and constants.
// Used by tcsc_datapath and tcsc_ctrl.
package tcsc_pkg;
  localparam int PageShift = 12;
  localparam logic ActInsert = 1'b0;
  localparam logic ActLookup = 1'b1;
  typedef enum logic [1:0] {
    StDone = 2'd0, StMiss = 2'd1, StZero = 2'd2, StFull = 2'd3
  } status_t;
endpackage

// ===== rtl/tcsc_if.sv =====
// Request and result channel interfaces with valid/ready handshake.
// Depends on nothing.
interface tcsc_req_if;
  logic valid;
  logic ready;
  logic action;
  logic [63:0] virt_addr;
  logic [63:0] phys_addr;
  modport source(output valid, action, virt_addr, phys_addr, input ready);
  modport sink(input valid, action, virt_addr, phys_addr, output ready);
endinterface

interface tcsc_rsp_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [63:0] found_addr;
  modport source(output valid, status, found_addr, input ready);
  modport sink(input valid, status, found_addr, output ready);
endinterface

// ===== rtl/tcsc_datapath.sv =====
// Datapath of the translation cache: slot and overflow stores, counters and scan pointer.
// Depends on tcsc_pkg; commanded by tcsc_ctrl.
module tcsc_datapath #(
  parameter int SLOTS = 16,
  parameter int CHAIN_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        ld_req,
  input  logic        act_in,
  input  logic [63:0] va_in,
  input  logic [63:0] pa_in,
  input  logic        scan_start,
  input  logic        scan_step,
  input  logic        do_insert,
  input  logic        lk_start,
  input  logic        lk_step,
  output logic        act,
  output logic        zero_addr,
  output logic        need_evict,
  output logic        scan_end,
  output logic        ins_full,
  output logic        prim_hit,
  output logic        ov_hit,
  output logic        ov_end,
  output logic [63:0] found_val
);
  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(CHAIN_DEPTH + 1);
  localparam int KW = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int OD = SLOTS * CHAIN_DEPTH;
  localparam int OW = $clog2(OD);
  localparam int TW = $clog2(SLOTS * (CHAIN_DEPTH + 1) + 1);
  localparam int PW = $clog2(2 * SLOTS + 1);
  localparam int PageShiftIdx = tcsc_pkg::PageShift;

  logic [63:0] slot_key [SLOTS];
  logic [63:0] slot_value [SLOTS];
  logic [SLOTS-1:0] slot_valid, slot_chance;
  logic [CW-1:0] overflow_fill [SLOTS];
  logic [63:0] ov_key [OD];
  logic [63:0] ov_val [OD];
  logic [TW-1:0] total_count;
  logic [63:0] va, pa;
  logic [SW-1:0] s, si;
  logic [PW-1:0] steps;
  logic [CW-1:0] k;
  logic [63:0] ov_key_q, ov_val_q;
  logic [OW-1:0] rd_addr;

  assign s = va[PageShiftIdx +: SW];
  assign zero_addr = (va == 64'd0) || (!act && pa == 64'd0);
  assign need_evict = total_count >= TW'(SLOTS - 1);
  assign scan_end = (steps == PW'(2 * SLOTS));
  assign ins_full = slot_valid[s] && overflow_fill[s] >= CW'(CHAIN_DEPTH);
  assign prim_hit = slot_valid[s] && slot_key[s] == va;
  assign ov_end = (k >= overflow_fill[s]);
  assign ov_hit = ov_key_q == va;
  assign rd_addr = OW'(s) * OW'(CHAIN_DEPTH) + OW'(k[KW-1:0]);

  always_comb begin
    found_val = ov_val_q;
    if (prim_hit) begin
      found_val = slot_value[s];
    end
  end

  always_ff @(posedge clk) begin
    ov_key_q <= ov_key[rd_addr];
    ov_val_q <= ov_val[rd_addr];
    if (do_insert && slot_valid[s] && !ins_full) begin
      ov_key[OW'(s) * OW'(CHAIN_DEPTH) + OW'(overflow_fill[s][KW-1:0])] <= va;
      ov_val[OW'(s) * OW'(CHAIN_DEPTH) + OW'(overflow_fill[s][KW-1:0])] <= pa;
    end
    if (do_insert && !slot_valid[s]) begin
      slot_key[s] <= va;
      slot_value[s] <= pa;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_chance <= '0;
      total_count <= '0;
      steps <= '0;
      si <= '0;
      k <= '0;
      act <= 1'b0;
      va <= '0;
      pa <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        overflow_fill[i] <= '0;
      end
    end else begin
      if (ld_req) begin
        act <= act_in;
        va <= va_in;
        pa <= pa_in;
      end
      if (scan_start) begin
        si <= '0;
        steps <= '0;
      end
      if (scan_step) begin
        si <= (si == SW'(SLOTS - 1)) ? '0 : si + SW'(1);
        if (slot_chance[si]) begin
          steps <= steps + PW'(1);
          slot_chance[si] <= 1'b0;
        end else if (slot_valid[si]) begin
          steps <= PW'(2 * SLOTS);
          slot_valid[si] <= 1'b0;
          overflow_fill[si] <= '0;
          total_count <= total_count - TW'(overflow_fill[si]) - TW'(1);
        end else begin
          steps <= steps + PW'(1);
        end
      end
      if (do_insert) begin
        if (!slot_valid[s]) begin
          slot_valid[s] <= 1'b1;
          slot_chance[s] <= 1'b1;
          total_count <= total_count + TW'(1);
        end else if (!ins_full) begin
          overflow_fill[s] <= overflow_fill[s] + CW'(1);
          total_count <= total_count + TW'(1);
        end
      end
      if (lk_start) begin
        k <= '0;
        if (prim_hit) begin
          slot_chance[s] <= 1'b1;
        end
      end
      if (lk_step) begin
        k <= k + CW'(1);
      end
    end
  end
endmodule

// ===== rtl/tcsc_ctrl.sv =====
// Controller of the translation cache: sequences eviction, insert and lookup.
// Depends on tcsc_pkg; drives tcsc_datapath.
module tcsc_ctrl (
  input  logic        clk,
  input  logic        rst,
  tcsc_req_if.sink    req,
  tcsc_rsp_if.source  rsp,
  input  logic        act,
  input  logic        zero_addr,
  input  logic        need_evict,
  input  logic        scan_end,
  input  logic        ins_full,
  input  logic        prim_hit,
  input  logic        ov_hit,
  input  logic        ov_end,
  input  logic [63:0] found_val,
  output logic        ld_req,
  output logic        scan_start,
  output logic        scan_step,
  output logic        do_insert,
  output logic        lk_start,
  output logic        lk_step
);
  typedef enum logic [2:0] {
    Idle, Decode, Scan, Insert, LkPrim, LkWait, LkCheck, Respond
  } state_t;
  state_t state;
  logic [1:0] status;
  logic [63:0] found;

  assign req.ready = (state == Idle);
  assign ld_req = req.valid && req.ready;
  assign rsp.valid = (state == Respond);
  assign rsp.status = status;
  assign rsp.found_addr = found;
  assign scan_start = (state == Decode);
  assign scan_step = (state == Scan) && !scan_end;
  assign do_insert = (state == Insert);
  assign lk_start = (state == LkPrim);
  assign lk_step = (state == LkCheck) && !ov_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Idle;
      status <= tcsc_pkg::StDone;
      found <= '0;
    end else begin
      case (state)
        Idle: begin
          if (ld_req) begin
            state <= Decode;
          end
        end
        Decode: begin
          found <= '0;
          if (zero_addr) begin
            status <= tcsc_pkg::StZero;
            state <= Respond;
          end else begin
            status <= tcsc_pkg::StDone;
            if (act == tcsc_pkg::ActLookup) begin
              state <= LkPrim;
            end else if (need_evict) begin
              state <= Scan;
            end else begin
              state <= Insert;
            end
          end
        end
        Scan: begin
          if (scan_end) begin
            state <= Insert;
          end
        end
        Insert: begin
          if (ins_full) begin
            status <= tcsc_pkg::StFull;
          end
          state <= Respond;
        end
        LkPrim: begin
          if (prim_hit) begin
            found <= found_val;
            state <= Respond;
          end else begin
            state <= LkWait;
          end
        end
        LkWait: begin
          if (ov_end) begin
            status <= tcsc_pkg::StMiss;
            state <= Respond;
          end else begin
            state <= LkCheck;
          end
        end
        LkCheck: begin
          if (ov_hit) begin
            found <= found_val;
            state <= Respond;
          end else begin
            state <= LkWait;
          end
        end
        Respond: begin
          if (rsp.ready) begin
            state <= Idle;
          end
        end
        default: state <= Idle;
      endcase
    end
  end
endmodule

// ===== rtl/translation_cache_second_chance.sv =====
// Top level of the translation cache with second-chance replacement.
// Depends on tcsc_if, tcsc_ctrl and tcsc_datapath.
// One request is handled at a time. An accepted request is decoded first; a
// rejected zero address goes straight to the response. A lookup checks the
// primary slot, then reads each overflow entry in turn (wait, then check) and
// misses when it reaches the end of the overflow list. An insert runs the clock
// eviction scan over the primary slots first when eviction is needed. A stalled
// result is held until it is taken.
module translation_cache_second_chance #(
  parameter int SLOTS = 16,
  parameter int CHAIN_DEPTH = 4
) (
  input logic        clk,
  input logic        rst,
  tcsc_req_if.sink   req,
  tcsc_rsp_if.source rsp
);
  logic act, zero_addr, need_evict, scan_end, ins_full, prim_hit, ov_hit, ov_end;
  logic ld_req, scan_start, scan_step, do_insert, lk_start, lk_step;
  logic [63:0] found_val;

  tcsc_ctrl u_ctrl (
    .clk, .rst, .req, .rsp, .act, .zero_addr, .need_evict, .scan_end, .ins_full,
    .prim_hit, .ov_hit, .ov_end, .found_val, .ld_req, .scan_start, .scan_step,
    .do_insert, .lk_start, .lk_step
  );

  tcsc_datapath #(.SLOTS(SLOTS), .CHAIN_DEPTH(CHAIN_DEPTH)) u_dp (
    .clk, .rst, .ld_req, .act_in(req.action), .va_in(req.virt_addr),
    .pa_in(req.phys_addr), .scan_start, .scan_step, .do_insert, .lk_start,
    .lk_step, .act, .zero_addr, .need_evict, .scan_end, .ins_full, .prim_hit,
    .ov_hit, .ov_end, .found_val
  );
endmodule
